// ===== rtl/gras_pkg.sv =====
// Package for the grid range aggregate store: command kinds, controller
// states and the controller/datapath command and status structs. No dependencies.
`default_nettype none
package gras_pkg;

   // command kinds
   localparam logic [2:0] KIND_WRITE = 3'd0;
   localparam logic [2:0] KIND_SUM   = 3'd1;
   localparam logic [2:0] KIND_MAX   = 3'd2;
   localparam logic [2:0] KIND_MIN   = 3'd3;
   localparam logic [2:0] KIND_MEAN  = 3'd4;

   localparam logic signed [31:0] INT_MAX = 32'sh7fffffff;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b0_0000_0001,
      ST_CLEAR = 9'b0_0000_0010,
      ST_FIRST = 9'b0_0000_0100,
      ST_WALK  = 9'b0_0000_1000,
      ST_DRAIN = 9'b0_0001_0000,
      ST_PREP  = 9'b0_0010_0000,
      ST_DIV   = 9'b0_0100_0000,
      ST_STORE = 9'b0_1000_0000,
      ST_DONE  = 9'b1_0000_0000
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture command, begin corner read
      logic clear_step; // write zero at clear pointer
      logic walk_step;  // issue next rectangle read
      logic acc_en;     // fold registered read data
      logic div_init;
      logic div_step;
      logic store;      // write result to target
      logic respond;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic rect_empty;
      logic walk_last;
      logic div_last;
      logic is_mean;
      logic count_zero;
   } dp_stat_type;

endpackage
`default_nettype wire

// ===== rtl/gras_ctrl.sv =====
// Controller state machine for the grid range aggregate store.
// Depends on gras_pkg.
`default_nettype none
module gras_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   output gras_pkg::dp_cmd_type      cmd,
   input  wire gras_pkg::dp_stat_type stat
);

   gras_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gras_pkg::ST_CLEAR: if (stat.clear_last) state_in = gras_pkg::ST_IDLE;
         gras_pkg::ST_IDLE:  if (start) state_in = gras_pkg::ST_FIRST;
         gras_pkg::ST_FIRST: state_in = (stat.rect_empty || stat.walk_last)
                                        ? gras_pkg::ST_DRAIN : gras_pkg::ST_WALK;
         gras_pkg::ST_WALK:  if (stat.walk_last) state_in = gras_pkg::ST_DRAIN;
         gras_pkg::ST_DRAIN: state_in = gras_pkg::ST_PREP;
         gras_pkg::ST_PREP:  state_in = (stat.is_mean && !stat.count_zero)
                                        ? gras_pkg::ST_DIV : gras_pkg::ST_STORE;
         gras_pkg::ST_DIV:   if (stat.div_last) state_in = gras_pkg::ST_STORE;
         gras_pkg::ST_STORE: state_in = gras_pkg::ST_DONE;
         gras_pkg::ST_DONE:  state_in = gras_pkg::ST_IDLE;
         default:            state_in = gras_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= gras_pkg::ST_CLEAR;
      else       state_ff <= state_in;
   end

   // commands
   always_comb begin
      cmd            = '0;
      cmd.clear_step = (state_ff == gras_pkg::ST_CLEAR);
      cmd.load       = (state_ff == gras_pkg::ST_IDLE) && start;
      cmd.walk_step  = (state_ff == gras_pkg::ST_FIRST && !stat.rect_empty
                        && !stat.walk_last)
                    || (state_ff == gras_pkg::ST_WALK && !stat.walk_last);
      cmd.acc_en     = (state_ff == gras_pkg::ST_WALK) || (state_ff == gras_pkg::ST_DRAIN);
      cmd.div_init   = (state_ff == gras_pkg::ST_PREP);
      cmd.div_step   = (state_ff == gras_pkg::ST_DIV);
      cmd.store      = (state_ff == gras_pkg::ST_STORE);
      cmd.respond    = (state_ff == gras_pkg::ST_DONE);
   end

   assign busy = (state_ff != gras_pkg::ST_IDLE);

endmodule
`default_nettype wire

// ===== rtl/gras_datapath.sv =====
// Datapath: cell memory, rectangle walker, reductions and radix-2 divider.
// Depends on gras_pkg.
`default_nettype none
module gras_datapath #(
   parameter int ROWS = 32,
   parameter int COLS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire gras_pkg::dp_cmd_type cmd,
   output gras_pkg::dp_stat_type    stat,
   input  wire logic [2:0]          req_kind,
   input  wire logic [4:0]          req_target_row,
   input  wire logic [2:0]          req_target_col,
   input  wire logic signed [31:0]  req_literal,
   input  wire logic [4:0]          req_first_row,
   input  wire logic [2:0]          req_first_col,
   input  wire logic [4:0]          req_last_row,
   input  wire logic [2:0]          req_last_col,
   output logic signed [31:0]       rsp_written,
   output logic                     rsp_failed
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   logic [31:0] mem [DEPTH];

   // captured command
   logic [2:0]         kind_ff;
   logic [4:0]         trow_ff, frow_ff, lrow_ff, row_ff;
   logic [2:0]         tcol_ff, fcol_ff, lcol_ff, col_ff;
   logic signed [31:0] lit_ff;

   // read pipeline
   logic [31:0] rdata_ff;
   logic        rin_ff;        // read cell lies inside grid
   logic        load_d_ff;     // corner address is being read
   logic        first_rd_ff;   // registered read is the corner
   logic [AW-1:0] clr_ff;

   // accumulators
   logic [31:0]        sum_ff;
   logic signed [31:0] mx_ff, mn_ff;
   logic [CW-1:0]      cnt_ff;

   // divider
   logic [31:0] quo_ff, rem_ff, den_ff;
   logic [5:0]  bit_ff;
   logic        neg_ff;
   logic signed [31:0] result_ff;
   logic        fail_ff;
   logic signed [31:0] quot_s;

   // address of current walk cell
   logic        in_grid;
   logic [AW-1:0] raddr;
   logic [AW+5:0] lin;
   assign in_grid = (32'(row_ff) < ROWS) && (32'(col_ff) < COLS);
   assign lin     = (AW+6)'(row_ff) * (AW+6)'(COLS) + (AW+6)'(col_ff);
   assign raddr   = lin[AW-1:0];

   logic        t_in;
   logic [AW+5:0] tlin;
   assign t_in = (32'(trow_ff) < ROWS) && (32'(tcol_ff) < COLS);
   assign tlin = (AW+6)'(trow_ff) * (AW+6)'(COLS) + (AW+6)'(tcol_ff);

   // signed mean from the magnitude quotient
   assign quot_s = neg_ff ? signed'(~quo_ff + 32'd1) : signed'(quo_ff);

   // status
   assign stat.clear_last = (32'(clr_ff) == DEPTH - 1);
   assign stat.rect_empty = (frow_ff > lrow_ff) || (fcol_ff > lcol_ff);
   assign stat.walk_last  = (row_ff == lrow_ff) && (col_ff == lcol_ff);
   assign stat.div_last   = (bit_ff == 6'd0);
   assign stat.is_mean    = (kind_ff == gras_pkg::KIND_MEAN);
   assign stat.count_zero = (cnt_ff == '0);

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.clear_step)
         mem[clr_ff] <= '0;
      else if (cmd.store && t_in && !fail_ff && kind_ff <= gras_pkg::KIND_MEAN)
         mem[tlin[AW-1:0]] <= (kind_ff == gras_pkg::KIND_MEAN) ? quot_s : result_ff;
      rdata_ff <= mem[raddr];
   end

   // clear pointer
   always_ff @(posedge clock) begin
      if (reset)              clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + AW'(1);
   end

   // command capture and rectangle walk
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         trow_ff <= req_target_row;
         tcol_ff <= req_target_col;
         lit_ff  <= req_literal;
         frow_ff <= req_first_row;
         fcol_ff <= req_first_col;
         lrow_ff <= req_last_row;
         lcol_ff <= req_last_col;
         row_ff  <= req_first_row;
         col_ff  <= req_first_col;
      end else if (cmd.walk_step) begin
         if (col_ff == lcol_ff) begin
            col_ff <= fcol_ff;
            row_ff <= row_ff + 5'd1;
         end else begin
            col_ff <= col_ff + 3'd1;
         end
      end
      rin_ff      <= in_grid;
      load_d_ff   <= cmd.load;
      first_rd_ff <= load_d_ff;
   end

   // reductions; max seeds from the registered corner read, flagged by first_rd_ff
   logic [31:0] v;
   assign v = rin_ff ? rdata_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (cmd.acc_en) begin
         if (first_rd_ff && stat.rect_empty) begin
            sum_ff <= '0;
            mx_ff  <= signed'(v);
            mn_ff  <= gras_pkg::INT_MAX;
            cnt_ff <= '0;
         end else begin
            sum_ff <= (first_rd_ff ? 32'd0 : sum_ff) + v;
            if (first_rd_ff) mx_ff <= signed'(v);
            else if (signed'(v) > mx_ff) mx_ff <= signed'(v);
            if (first_rd_ff || signed'(v) < mn_ff) mn_ff <= signed'(v);
            cnt_ff <= (first_rd_ff ? CW'(0) : cnt_ff) + CW'(v != 0);
         end
      end
   end

   // restoring divider on magnitudes, one quotient bit per cycle
   logic [32:0] trial;
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         quo_ff <= sum_ff[31] ? (~sum_ff + 32'd1) : sum_ff;
         rem_ff <= '0;
         den_ff <= 32'(cnt_ff);
         neg_ff <= sum_ff[31];
         bit_ff <= 6'd31;
      end else if (cmd.div_step) begin
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], quo_ff[31]};
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
         bit_ff <= bit_ff - 6'd1;
      end
   end

   // result select (settles in PREP / DIV, mean quotient taken at STORE)
   always_ff @(posedge clock) begin
      if (cmd.div_init || cmd.div_step) begin
         fail_ff <= (kind_ff == gras_pkg::KIND_MEAN) && stat.count_zero;
         case (kind_ff)
            gras_pkg::KIND_WRITE: result_ff <= lit_ff;
            gras_pkg::KIND_SUM:   result_ff <= signed'(sum_ff);
            gras_pkg::KIND_MAX:   result_ff <= mx_ff;
            gras_pkg::KIND_MIN:   result_ff <= mn_ff;
            gras_pkg::KIND_MEAN:  result_ff <= '0;
            default:              result_ff <= '0;
         endcase
      end
      if (cmd.store && kind_ff == gras_pkg::KIND_MEAN && !fail_ff)
         result_ff <= quot_s;
   end

   assign rsp_written = result_ff;
   assign rsp_failed  = fail_ff;

endmodule
`default_nettype wire

// ===== rtl/grid_range_aggregate_store_unit.sv =====
// Grid range aggregate store, top level. Depends on gras_pkg, gras_ctrl,
// gras_datapath.
//
// A command is taken when start is high and busy is low. The unit reads the
// rectangle one cell per cycle from its cell memory, then runs a 32-step
// restoring divider for a mean with a nonzero count. After reset a clearing
// pass zeroes the ROWS*COLS cells, one per cycle, with busy high. The result
// appears for one cycle with rsp_valid; the receiver cannot stall it.
`default_nettype none
module grid_range_aggregate_store_unit #(
   parameter int ROWS = 32,
   parameter int COLS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_kind,
   input  wire logic [4:0]         req_target_row,
   input  wire logic [2:0]         req_target_col,
   input  wire logic signed [31:0] req_literal,
   input  wire logic [4:0]         req_first_row,
   input  wire logic [2:0]         req_first_col,
   input  wire logic [4:0]         req_last_row,
   input  wire logic [2:0]         req_last_col,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_written,
   output logic                    rsp_failed
);

   gras_pkg::dp_cmd_type  cmd;
   gras_pkg::dp_stat_type stat;

   gras_ctrl u_ctrl (
      .clock (clock), .reset (reset), .start (start), .busy (busy),
      .cmd (cmd), .stat (stat)
   );

   gras_datapath #(.ROWS (ROWS), .COLS (COLS)) u_dp (
      .clock (clock), .reset (reset), .cmd (cmd), .stat (stat),
      .req_kind (req_kind), .req_target_row (req_target_row),
      .req_target_col (req_target_col), .req_literal (req_literal),
      .req_first_row (req_first_row), .req_first_col (req_first_col),
      .req_last_row (req_last_row), .req_last_col (req_last_col),
      .rsp_written (rsp_written), .rsp_failed (rsp_failed)
   );

   assign rsp_valid = cmd.respond;

   // a failed mean always reports zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |-> rsp_written == 32'sd0)
      else $error("failed result with nonzero value");

   // a response only ends a busy command
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response while idle");

   // an accepted command raises busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accept did not start work");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for grid_range_aggregate_store_unit: directed and random grid commands,
// each result checked against a predictor with its own copy of the cell grid.
// Depends on gras_pkg and the RTL top level.
`timescale 1ns / 1ps
`default_nettype none
module tb;

   localparam int NROW = 32;
   localparam int NCOL = 8;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      logic [2:0]         kind;
      logic [4:0]         trow;
      logic [2:0]         tcol;
      logic signed [31:0] lit;
      logic [4:0]         frow;
      logic [2:0]         fcol;
      logic [4:0]         lrow;
      logic [2:0]         lcol;
   } grid_cmd_type;

   typedef struct {
      logic signed [31:0] written;
      logic               failed;
   } grid_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_kind = '0;
   logic [4:0] req_target_row = '0;
   logic [2:0] req_target_col = '0;
   logic signed [31:0] req_literal = '0;
   logic [4:0] req_first_row = '0;
   logic [2:0] req_first_col = '0;
   logic [4:0] req_last_row = '0;
   logic [2:0] req_last_col = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_written;
   logic rsp_failed;

   grid_cmd_type pending_cmds[$];
   grid_rsp_type expected_rsps[$];
   logic signed [31:0] shadow_grid[NROW][NCOL];
   int  error_count = 0;
   longint cycle_count = 0;
   bit  stim_done = 1'b0;
   bit  drv_hold = 1'b0;   // pause driver until everything drains
   int  gap_left = 0;
   int  burst_left = 0;

   grid_range_aggregate_store_unit #(.ROWS(NROW), .COLS(NCOL)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_target_row(req_target_row),
      .req_target_col(req_target_col), .req_literal(req_literal),
      .req_first_row(req_first_row), .req_first_col(req_first_col),
      .req_last_row(req_last_row), .req_last_col(req_last_col),
      .rsp_valid(rsp_valid), .rsp_written(rsp_written), .rsp_failed(rsp_failed)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // apply one command to the shadow grid, queue its expected result
   function automatic void predict_aggregate(grid_cmd_type c);
      logic [31:0] sum;
      logic signed [31:0] mx, mn, v, res;
      int count;
      logic failed, store;
      longint q;
      sum = 0; mn = gras_pkg::INT_MAX; count = 0; failed = 0; store = 0; res = 0;
      mx = shadow_grid[c.frow][c.fcol];
      for (int r = c.frow; r <= c.lrow; r++)
         for (int k = c.fcol; k <= c.lcol; k++) begin
            v = shadow_grid[r][k];
            sum += v;
            if (v > mx) mx = v;
            if (v < mn) mn = v;
            if (v != 0) count++;
         end
      case (c.kind)
         gras_pkg::KIND_WRITE: begin res = c.lit; store = 1; end
         gras_pkg::KIND_SUM:   begin res = sum;   store = 1; end
         gras_pkg::KIND_MAX:   begin res = mx;    store = 1; end
         gras_pkg::KIND_MIN:   begin res = mn;    store = 1; end
         gras_pkg::KIND_MEAN: begin
            if (count == 0) failed = 1;
            else begin
               q = longint'($signed(sum)) / count;
               res = q[31:0];
               store = 1;
            end
         end
         default: ;
      endcase
      if (store) shadow_grid[c.trow][c.tcol] = res;
      expected_rsps.push_back('{res, failed});
   endfunction

   function automatic grid_cmd_type make_cmd(logic [2:0] k, int tr, int tc, int lit,
                                             int fr, int fc, int lr, int lc);
      grid_cmd_type c;
      c.kind = k; c.trow = 5'(tr); c.tcol = 3'(tc); c.lit = lit;
      c.frow = 5'(fr); c.fcol = 3'(fc); c.lrow = 5'(lr); c.lcol = 3'(lc);
      return c;
   endfunction

   // mostly small rectangles; a few full-height walks
   function automatic grid_cmd_type rand_cmd();
      grid_cmd_type c;
      int h, w;
      c.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
      c.trow = 5'($urandom); c.tcol = 3'($urandom);
      case ($urandom_range(0, 3))
         0: c.lit = $urandom;
         1: c.lit = $signed($urandom_range(0, 20)) - 10;
         2: c.lit = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: c.lit = $urandom_range(0, 1000);
      endcase
      h = ($urandom_range(0, 49) == 0) ? 31 : $urandom_range(0, 4);
      w = $urandom_range(0, 7);
      c.frow = 5'($urandom_range(0, 31 - h));
      c.fcol = 3'($urandom_range(0, 7 - w));
      c.lrow = 5'(c.frow + h);
      c.lcol = 3'(c.fcol + w);
      if ($urandom_range(0, 14) == 0) begin   // empty rectangle now and then
         c.frow = 5'($urandom); c.fcol = 3'($urandom);
         c.lrow = 5'($urandom); c.lcol = 3'($urandom);
      end
      return c;
   endfunction

   // stimulus: directed beats, then random ones
   initial begin
      for (int r = 0; r < NROW; r++)
         for (int k = 0; k < NCOL; k++) shadow_grid[r][k] = 0;
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_MEAN, 0, 0, 0, 0, 0, 31, 7)); // empty grid
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_MAX, 1, 1, 0, 0, 0, 31, 7));
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_WRITE, 0, 0, 32'sh7fffffff, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_WRITE, 31, 7, 32'sh80000000, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_WRITE, 0, 7, -1, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_WRITE, 31, 0, 5, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_SUM, 10, 3, 0, 0, 0, 31, 7));  // wraps
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_MAX, 11, 3, 0, 0, 0, 31, 7));
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_MIN, 12, 3, 0, 0, 0, 31, 7));
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_MEAN, 13, 3, 0, 0, 0, 31, 7));
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_MEAN, 14, 3, 0, 31, 0, 31, 7)); // negative
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_SUM, 2, 2, 0, 5, 0, 4, 7));  // empty rects
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_MAX, 2, 3, 0, 0, 7, 31, 6));
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_MIN, 2, 4, 0, 9, 0, 3, 7));
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_MEAN, 2, 5, 0, 31, 7, 0, 0));
      pending_cmds.push_back(make_cmd(3'd5, 3, 3, 99, 0, 0, 1, 1));          // unused kinds
      pending_cmds.push_back(make_cmd(3'd6, 3, 4, 99, 0, 0, 1, 1));
      pending_cmds.push_back(make_cmd(3'd7, 3, 5, -99, 31, 7, 31, 7));
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_MAX, 4, 4, 0, 31, 7, 31, 7)); // one cell
      pending_cmds.push_back(make_cmd(gras_pkg::KIND_SUM, 0, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < 600; i++) pending_cmds.push_back(rand_cmd());
   end

   // driver: random bursts and gaps, one drain pause midway
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == 7) reset <= 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            predict_aggregate('{req_kind, req_target_row, req_target_col, req_literal,
                                req_first_row, req_first_col, req_last_row,
                                req_last_col});
            if (pending_cmds.size() == 320) drv_hold <= 1'b1;
         end
         if (drv_hold && expected_rsps.size() == 0 && !(start && !busy))
            drv_hold <= 1'b0;
         if (start && busy) begin
            // hold the beat until taken
         end else if (pending_cmds.size() == 0 || drv_hold) begin
            start <= 1'b0;
            if (pending_cmds.size() == 0 && !start) stim_done <= 1'b1;
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else begin
            grid_cmd_type c;
            c = pending_cmds.pop_front();
            start <= 1'b1;
            req_kind <= c.kind; req_target_row <= c.trow; req_target_col <= c.tcol;
            req_literal <= c.lit; req_first_row <= c.frow; req_first_col <= c.fcol;
            req_last_row <= c.lrow; req_last_col <= c.lcol;
            if (burst_left > 0) burst_left <= burst_left - 1;
            else begin
               burst_left <= $urandom_range(0, 6);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end
         end
      end
   end

   // monitor: compare each result beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result written=%0d failed=%0b", $time,
                     rsp_written, rsp_failed);
            error_count++;
         end else begin
            grid_rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_written !== e.written) begin
               $display("%0t: written expected %0d actual %0d", $time, e.written,
                        rsp_written);
               error_count++;
            end
            if (rsp_failed !== e.failed) begin
               $display("%0t: failed expected %0b actual %0b", $time, e.failed,
                        rsp_failed);
               error_count++;
            end
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      while (expected_rsps.size() != 0 && cycle_count < CYCLE_LIMIT) @(posedge clock);
      repeat (400) @(posedge clock);
      if (cycle_count >= CYCLE_LIMIT || expected_rsps.size() != 0) error_count++;
      if (error_count == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT + 1000);
      $display("tb: done, errors");
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/gras_pkg.sv
rtl/gras_ctrl.sv
rtl/gras_datapath.sv
rtl/grid_range_aggregate_store_unit.sv
sim/tb.sv
